[rtl/air_quality_frame_window_decider_assert.svh]
// ----------------------------------------------------------------------------
// air quality frame window decider assertion macros
// shared property wrappers for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef AIR_QUALITY_FRAME_WINDOW_DECIDER_ASSERT_SVH
`define AIR_QUALITY_FRAME_WINDOW_DECIDER_ASSERT_SVH

// condition holds at every edge out of reset
`define AQFWD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define AQFWD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define AQFWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/aqfwd_pkg.sv]
// ----------------------------------------------------------------------------
// aqfwd_pkg
// shared types, codes and helper functions of the air quality frame decider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aqfwd_pkg;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned LEVEL_W = 2;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned INDEX_W = 8;

   localparam logic [VALUE_W-1:0] SAT_MAX = 16'hFFFF;

   localparam logic [VALUE_W-1:0] CO2_BAD_RESET = 16'd500;
   localparam logic [VALUE_W-1:0] CO2_MID_RESET = 16'd400;
   localparam logic [VALUE_W-1:0] DUST_BAD_RESET = 16'd700;
   localparam logic [VALUE_W-1:0] DUST_GOOD_RESET = 16'd500;

   localparam logic [BYTE_W-1:0] CHAR_CO2 = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_DUST = 8'h44;
   localparam logic [BYTE_W-1:0] CHAR_END = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

   localparam logic [INDEX_W-1:0] REG_CO2_BAD = 8'd0;
   localparam logic [INDEX_W-1:0] REG_CO2_MID = 8'd1;
   localparam logic [INDEX_W-1:0] REG_DUST_BAD = 8'd2;
   localparam logic [INDEX_W-1:0] REG_DUST_GOOD = 8'd3;

   localparam logic [LEVEL_W-1:0] LEVEL_BAD = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MODERATE = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_GOOD = 2'd3;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_CO2 = 2'd1,
      MODE_DUST = 2'd2
   } parse_mode_type;

   typedef struct packed {
      logic [VALUE_W-1:0] co2;
      logic [VALUE_W-1:0] dust;
   } frame_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] co2_level;
      logic [LEVEL_W-1:0] dust_level;
      logic decided;
      logic window_open;
      logic send_command;
   } decision_type;

   typedef struct packed {
      logic valid;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] data;
   } csr_write_type;

   function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] acc,
                                                    input logic [3:0] digit);
      logic [VALUE_W+3:0] wide;
      logic [VALUE_W+3:0] sum;
      wide = {4'b0000, acc};
      sum = (wide << 3) + (wide << 1) + {16'h0000, digit};
      return (sum > {4'b0000, SAT_MAX}) ? SAT_MAX : sum[VALUE_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] classify(input logic [VALUE_W-1:0] value,
                                                   input logic [VALUE_W-1:0] bad,
                                                   input logic [VALUE_W-1:0] good);
      logic [LEVEL_W-1:0] level;
      if (value > bad) begin
         level = LEVEL_BAD;
      end else if (value > good) begin
         level = LEVEL_MODERATE;
      end else begin
         level = LEVEL_GOOD;
      end
      return level;
   endfunction

endpackage

[rtl/aqfwd_parser.sv]
// ----------------------------------------------------------------------------
// aqfwd_parser
// frame parser: marker tracking and saturating decimal accumulators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aqfwd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [aqfwd_pkg::BYTE_W-1:0] rx_byte,
   output aqfwd_pkg::frame_type         frame
);

   aqfwd_pkg::parse_mode_type mode_ff, mode_in;
   logic [aqfwd_pkg::VALUE_W-1:0] co2_ff, co2_in;
   logic [aqfwd_pkg::VALUE_W-1:0] dust_ff, dust_in;
   logic ended_ff, ended_in;
   logic is_digit;

   assign is_digit = (rx_byte >= aqfwd_pkg::CHAR_ZERO) && (rx_byte <= aqfwd_pkg::CHAR_NINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= aqfwd_pkg::MODE_IDLE;
         co2_ff <= '0;
         dust_ff <= '0;
         ended_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         co2_ff <= co2_in;
         dust_ff <= dust_in;
         ended_ff <= ended_in;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      co2_in = co2_ff;
      dust_in = dust_ff;
      ended_in = ended_ff;
      if (step) begin
         if (rx_byte == aqfwd_pkg::CHAR_CO2) begin
            co2_in = '0;
            dust_in = '0;
            ended_in = 1'b0;
            mode_in = aqfwd_pkg::MODE_CO2;
         end else if (rx_byte == aqfwd_pkg::CHAR_DUST) begin
            dust_in = '0;
            ended_in = 1'b0;
            mode_in = aqfwd_pkg::MODE_DUST;
         end else if (rx_byte == aqfwd_pkg::CHAR_END) begin
            co2_in = '0;
            dust_in = '0;
            ended_in = 1'b0;
            mode_in = aqfwd_pkg::MODE_IDLE;
         end else begin
            case (mode_ff)
               aqfwd_pkg::MODE_CO2: begin
                  if (!is_digit) begin
                     ended_in = 1'b1;
                  end else if (!ended_ff) begin
                     co2_in = aqfwd_pkg::add_digit(co2_ff, rx_byte[3:0]);
                  end
               end
               aqfwd_pkg::MODE_DUST: begin
                  if (!is_digit) begin
                     ended_in = 1'b1;
                  end else if (!ended_ff) begin
                     dust_in = aqfwd_pkg::add_digit(dust_ff, rx_byte[3:0]);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign frame.co2 = co2_ff;
   assign frame.dust = dust_ff;

endmodule

[rtl/aqfwd_decider.sv]
// ----------------------------------------------------------------------------
// aqfwd_decider
// threshold registers, level classification and window command tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aqfwd_decider (
   input  logic                     clock,
   input  logic                     reset,
   input  aqfwd_pkg::csr_write_type csr_wr,
   input  logic                     end_step,
   input  logic                     auto_mode,
   input  logic                     prio_open,
   input  aqfwd_pkg::frame_type     frame,
   output aqfwd_pkg::decision_type  result
);

   logic [aqfwd_pkg::VALUE_W-1:0] co2_bad_ff, co2_bad_in;
   logic [aqfwd_pkg::VALUE_W-1:0] co2_mid_ff, co2_mid_in;
   logic [aqfwd_pkg::VALUE_W-1:0] dust_bad_ff, dust_bad_in;
   logic [aqfwd_pkg::VALUE_W-1:0] dust_good_ff, dust_good_in;
   logic last_cmd_ff, last_cmd_in;
   logic last_valid_ff, last_valid_in;
   logic [aqfwd_pkg::LEVEL_W-1:0] co2_level;
   logic [aqfwd_pkg::LEVEL_W-1:0] dust_level;
   logic open_choice;
   logic send;

   always_ff @(posedge clock) begin
      if (reset) begin
         co2_bad_ff <= aqfwd_pkg::CO2_BAD_RESET;
         co2_mid_ff <= aqfwd_pkg::CO2_MID_RESET;
         dust_bad_ff <= aqfwd_pkg::DUST_BAD_RESET;
         dust_good_ff <= aqfwd_pkg::DUST_GOOD_RESET;
         last_cmd_ff <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         co2_bad_ff <= co2_bad_in;
         co2_mid_ff <= co2_mid_in;
         dust_bad_ff <= dust_bad_in;
         dust_good_ff <= dust_good_in;
         last_cmd_ff <= last_cmd_in;
         last_valid_ff <= last_valid_in;
      end
   end

   always_comb begin
      co2_bad_in = co2_bad_ff;
      co2_mid_in = co2_mid_ff;
      dust_bad_in = dust_bad_ff;
      dust_good_in = dust_good_ff;
      if (csr_wr.valid) begin
         case (csr_wr.index)
            aqfwd_pkg::REG_CO2_BAD: co2_bad_in = csr_wr.data;
            aqfwd_pkg::REG_CO2_MID: co2_mid_in = csr_wr.data;
            aqfwd_pkg::REG_DUST_BAD: dust_bad_in = csr_wr.data;
            aqfwd_pkg::REG_DUST_GOOD: dust_good_in = csr_wr.data;
            default: begin
            end
         endcase
      end
   end

   assign co2_level = aqfwd_pkg::classify(frame.co2, co2_bad_ff, co2_mid_ff);
   assign dust_level = aqfwd_pkg::classify(frame.dust, dust_bad_ff, dust_good_ff);

   // higher level number means cleaner air
   assign open_choice = (co2_level > dust_level) ? 1'b1 :
                        (co2_level < dust_level) ? 1'b0 : prio_open;
   assign send = auto_mode && (!last_valid_ff || (last_cmd_ff != open_choice));

   assign last_cmd_in = (end_step && send) ? open_choice : last_cmd_ff;
   assign last_valid_in = last_valid_ff || (end_step && send);

   assign result.co2_level = co2_level;
   assign result.dust_level = dust_level;
   assign result.decided = auto_mode;
   assign result.window_open = auto_mode && open_choice;
   assign result.send_command = send;

endmodule

[rtl/air_quality_frame_window_decider.sv]
// ----------------------------------------------------------------------------
// air_quality_frame_window_decider
// parses C/D/E sensor frames and decides the window command
// ----------------------------------------------------------------------------
// usage:
//   req channel takes one link byte per transaction with the auto and
//   priority switches; every byte is accepted, but only an 'E' byte makes a
//   rsp transaction carrying both readings, their levels and the decision.
//   csr channel writes the four threshold registers, always ready; write it
//   only while no frame is in flight.
//   a byte is held in the input register, and its result is held in the
//   result register, which drives rsp.
//   throughput: one byte per cycle while rsp is not stalled, with the input
//   and result registers around the parse and classify step.
//   when rsp is stalled the result register holds; a following 'E' waits in
//   the input register and req_tready drops, other bytes keep flowing.
//   reset: parser idle, readings zero, thresholds 500/400/700/500, no
//   command sent yet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "air_quality_frame_window_decider_assert.svh"

module air_quality_frame_window_decider (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], auto_mode[8], prio_open[9], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // co2_reading[15:0], dust_reading[31:16], co2_level[33:32], dust_level[35:34],
   // decided[36], window_open[37], send_command[38], zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic in_valid_ff, in_valid_in;
   logic [aqfwd_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic in_auto_ff, in_auto_in;
   logic in_prio_ff, in_prio_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic in_is_end;
   logic rsp_free;
   logic step;
   logic end_step;

   aqfwd_pkg::frame_type frame;
   aqfwd_pkg::decision_type result;
   aqfwd_pkg::csr_write_type csr_wr;

   assign req_accept = req_tvalid && req_tready;
   assign in_is_end = (in_byte_ff == aqfwd_pkg::CHAR_END);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign step = in_valid_ff && (!in_is_end || rsp_free);
   assign end_step = step && in_is_end;
   assign req_tready = !in_valid_ff || step;

   assign csr_ready = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data = csr_data;

   assign in_valid_in = req_accept || (in_valid_ff && !step);
   assign in_byte_in = req_accept ? req_tdata[7:0] : in_byte_ff;
   assign in_auto_in = req_accept ? req_tdata[8] : in_auto_ff;
   assign in_prio_in = req_accept ? req_tdata[9] : in_prio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_auto_ff <= in_auto_in;
      in_prio_ff <= in_prio_in;
      rsp_data_ff <= rsp_data_in;
   end

   aqfwd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .frame   (frame)
   );

   aqfwd_decider u_decider (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .end_step  (end_step),
      .auto_mode (in_auto_ff),
      .prio_open (in_prio_ff),
      .frame     (frame),
      .result    (result)
   );

   assign rsp_valid_in = end_step || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in = end_step ? {1'b0, result.send_command, result.window_open,
                                    result.decided, result.dust_level, result.co2_level,
                                    frame.dust, frame.co2}
                                 : rsp_data_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `AQFWD_ASSERT_SAME(a_send_needs_decision, clock, reset, rsp_valid_ff,
      (!rsp_data_ff[38] || rsp_data_ff[36]), "send flagged without a decision")
   `AQFWD_ASSERT_ALWAYS(a_levels_nonzero, clock, reset,
      (!rsp_valid_ff || ((rsp_data_ff[33:32] != 2'd0) && (rsp_data_ff[35:34] != 2'd0))),
      "result carries a zero level")
   `AQFWD_ASSERT_NEXT(a_result_from_end, clock, reset, (!rsp_valid_ff && !end_step),
      !rsp_valid_ff, "result raised without an end marker")
   `AQFWD_ASSERT_NEXT(a_end_waits, clock, reset, (in_valid_ff && in_is_end && !rsp_free),
      (in_valid_ff && in_is_end), "end marker dropped while result stalled")

endmodule
